[hw/rtl/boids_flocking_step_top_defines.svh]
// Assertion macros used by the boids flock step top module.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef BOIDS_FLOCKING_STEP_TOP_DEFINES_SVH
`define BOIDS_FLOCKING_STEP_TOP_DEFINES_SVH

// ante holds in a cycle -> cons holds in that same cycle
`define BFS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define BFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bfs_pkg.sv]
// Types, constants and helpers of the boids flock step block.
// No dependencies; imported by bfs_div, bfs_sqrt and boids_flocking_step_top.
`timescale 1ns / 1ps
package bfs_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_BOID_COUNT    = 1'b0;
	localparam logic [CFG_IW-1:0] REG_UPDATE_PERIOD = 1'b1;

	// divider: signed numerator, positive denominator
	localparam int DIV_NW = 51;
	localparam int DIV_DW = 33;

	localparam logic signed [33:0] GAIN_COH   = 34'sd6553;
	localparam logic signed [17:0] TEND_THR   = 18'sd52428;
	localparam logic [63:0]        CLAMP_M2   = 64'd107374182400;
	localparam logic [31:0]        NEAR_D2    = 32'h4000_0000;

	localparam logic signed [31:0] BND_LO [3] = '{-32'sd1966080, -32'sd3276800, -32'sd9830400};
	localparam logic signed [31:0] BND_HI [3] = '{32'sd1966080, 32'sd655360, 32'sd655360};

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (x < -48'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

[hw/rtl/bfs_if.sv]
// Valid/ready channel interfaces of the boids flock step block.
// Depends on nothing; one interface per direction.
`timescale 1ns / 1ps
interface bfs_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [4:0]         boid_index;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [15:0]        time_step;
	logic [16:0]        intensity;

	modport source (output valid, command, boid_index, pos_x, pos_y, pos_z, time_step,
		intensity, input ready);
	modport sink (input valid, command, boid_index, pos_x, pos_y, pos_z, time_step,
		intensity, output ready);
endinterface

interface bfs_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         out_index;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               last;

	modport source (output valid, out_index, out_x, out_y, out_z, last, input ready);
	modport sink (input valid, out_index, out_x, out_y, out_z, last, output ready);
endinterface

[hw/rtl/bfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bfs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

[hw/rtl/bfs_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on bfs_pkg for widths and the status struct.
`timescale 1ns / 1ps
module bfs_div import bfs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0]        den,
	output logic signed [DIV_NW-1:0] quo,
	output unit_stat_t               stat
);
	logic              busy_q, done_q, neg_q;
	logic [5:0]        cnt_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_NW-1:0] quo_q, mag;
	logic [DIV_DW:0]   trial, diff;
	logic              ge;

	assign mag   = num[DIV_NW-1] ? unsigned'(-num) : unsigned'(num);
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else
					cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= num[DIV_NW-1];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign quo  = neg_q ? -signed'(quo_q) : signed'(quo_q);
	assign stat = '{busy: busy_q, done: done_q};
endmodule

[hw/rtl/bfs_sqrt.sv]
// Integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on bfs_pkg for the status struct.
`timescale 1ns / 1ps
module bfs_sqrt import bfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] val,
	output logic [31:0] root,
	output unit_stat_t  stat
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] v_q, r_q, b_q, t;

	assign t = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else
					cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= val;
			r_q <= '0;
			b_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + b_q;
			end else
				r_q <= r_q >> 1;
			b_q <= b_q >> 2;
		end
	end

	assign root = r_q[31:0];
	assign stat = '{busy: busy_q, done: done_q};
endmodule

[hw/rtl/boids_flocking_step_top.sv]
// Boids flock step: sequencer around position and velocity RAMs.
// Depends on bfs_pkg, bfs_if, bfs_ram, bfs_div, bfs_sqrt and the defines header.
//
// Use: in_ch carries commands. A load beat (command 0) stores a boid position,
// clears its velocity and returns one echo beat on out_ch with last set, from
// the LD_EMIT state once out_ch is free. A tick beat (command 1) adds
// time_step to the elapsed time; once that passes update_period every boid in
// use takes a flocking rule update in index order, later boids seeing the new
// state of earlier ones. Every tick returns one beat per boid, last on the
// final one. The user must make configuration writes only while the block is
// idle; the block itself does not enforce it. Throughput: one item at a time;
// in_ch.ready is high only when idle. A tick without update runs a RAM read,
// three multiplies and a write per boid. With an update, each boid also runs
// a pair loop over the RAM read port for every other boid, the speed square,
// the root when clamping, and two or three divisions per axis on the shared
// divider.
// Reset clears per-entry valid bits so all boids read as zero at once; no
// clearing pass. A stalled out_ch holds its beat; the sequencer waits before
// overwriting it.
`timescale 1ns / 1ps
`include "boids_flocking_step_top_defines.svh"
module boids_flocking_step_top import bfs_pkg::*; #(
	parameter int MAX_BOIDS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	bfs_in_if.sink            in_ch,
	bfs_out_if.source         out_ch
);
	localparam int AW  = (MAX_BOIDS > 1) ? $clog2(MAX_BOIDS) : 1;
	localparam int NHI = (MAX_BOIDS < 32) ? MAX_BOIDS : 32;

	typedef enum logic [4:0] {
		IDLE, LD_EMIT, RD_I, CAP_I, J_RD, J_CAP, J_SQ, J_COL, M2_SET, M2_CAP, M2_CHK,
		SQ_WAIT, K_DIVC, K_WDIVC, K_CCAP, K_WDIVA, K_TEND, K_TCAP, K_DIVV, K_WDIVV,
		WR_V, MV_SET, MV_CAP, EMIT
	} st_t;

	st_t st_q;

	logic [5:0]         bc_q;
	logic [15:0]        per_q;
	logic [31:0]        elapsed_q;
	logic               trig_q, clamp_q;
	logic [5:0]         n_q, i_q, j_q;
	logic [1:0]         k_q;
	logic [15:0]        dt_q;
	logic [16:0]        inten_q;
	logic signed [17:0] tend_q;
	logic [4:0]         eidx_q;

	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] np_q [3];
	logic signed [36:0] sp_q [3];
	logic signed [36:0] sv_q [3];
	logic signed [20:0] col_q [3];
	logic signed [32:0] d_q [3];
	logic [31:0]        sq_q;
	logic [63:0]        m2_q;
	logic [31:0]        mag_q;
	logic signed [39:0] acc_q;
	logic signed [33:0] ma_q, mb_q;

	logic               ov_q, olast_q;
	logic [4:0]         oidx_q;
	logic signed [31:0] ox_q, oy_q, oz_q;

	// memory ports
	logic               rd_re, pw_we, vw_we;
	logic [AW-1:0]      rd_addr, pw_addr, vw_addr;
	logic [95:0]        pw_data, vw_data, pos_rdata, vel_rdata, pos_rd, vel_rd;
	logic [MAX_BOIDS-1:0] pvld_q, vvld_q;
	logic               pvld_s1, vvld_s1;

	// shared units
	logic                     div_start, sq_start;
	logic signed [DIV_NW-1:0] div_num, div_q;
	logic [DIV_DW-1:0]        div_den;
	logic [31:0]              sq_root;
	unit_stat_t               div_st, sq_st;

	logic in_fire, slot_free, near, ld_ok;
	logic signed [67:0] prod;
	logic signed [31:0] sqv, pk, vk;
	logic signed [15:0] sd;
	logic signed [39:0] push, push_k, p16, vc;
	logic signed [33:0] dv, negp;
	logic [32:0]        esum;
	logic [31:0]        enew;
	logic [5:0]         n_new;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == IDLE);
	assign slot_free = !ov_q || out_ch.ready;
	assign ld_ok     = 32'(in_ch.boid_index) < MAX_BOIDS;

	assign prod = ma_q * mb_q;
	assign p16  = signed'(prod[55:16]);
	assign pk   = p_q[k_q];
	assign vk   = v_q[k_q];
	assign sd   = d_q[k_q][15:0];
	assign sqv  = sd * sd;
	assign dv   = 34'(signed'(div_q[31:0])) - 34'(vk);
	assign negp = -34'(pk);
	assign vc   = clamp_q ? div_q[39:0] : 40'(vk);
	assign push = signed'(({23'b0, inten_q} << 3) + ({23'b0, inten_q} << 1));
	assign push_k = (pk < BND_LO[k_q]) ? push : (pk > BND_HI[k_q]) ? -push : 40'sd0;

	assign esum  = {1'b0, elapsed_q} + {17'b0, in_ch.time_step};
	assign enew  = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
	assign n_new = (bc_q < 6'd2) ? 6'd2 : (bc_q > 6'(NHI)) ? 6'(NHI) : bc_q;

	always_comb begin
		near = 1'b1;
		for (int a = 0; a < 3; a++)
			if (!(d_q[a] > -33'sd32768 && d_q[a] < 33'sd32768))
				near = 1'b0;
	end

	assign pos_rd = pvld_s1 ? pos_rdata : '0;
	assign vel_rd = vvld_s1 ? vel_rdata : '0;

	always_comb begin
		rd_re     = 1'b0;
		rd_addr   = AW'(i_q);
		pw_we     = 1'b0;
		pw_addr   = AW'(i_q);
		pw_data   = {np_q[2], np_q[1], np_q[0]};
		vw_we     = 1'b0;
		vw_addr   = AW'(i_q);
		vw_data   = {v_q[2], v_q[1], v_q[0]};
		div_start = 1'b0;
		div_num   = 51'(sp_q[k_q]);
		div_den   = 33'(n_q - 6'd1);
		sq_start  = 1'b0;
		unique case (st_q)
			IDLE: begin
				if (in_fire && in_ch.command == CMD_LOAD && ld_ok) begin
					pw_we   = 1'b1;
					vw_we   = 1'b1;
					pw_addr = AW'(in_ch.boid_index);
					vw_addr = AW'(in_ch.boid_index);
					pw_data = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
					vw_data = '0;
				end
			end
			RD_I: rd_re = 1'b1;
			J_RD: begin
				rd_re   = (j_q != n_q) && (j_q != i_q);
				rd_addr = AW'(j_q);
			end
			M2_CHK: sq_start = (m2_q > CLAMP_M2);
			K_DIVC: div_start = 1'b1;
			K_CCAP: begin
				div_start = 1'b1;
				div_num   = 51'(sv_q[k_q]);
			end
			K_DIVV: begin
				div_start = clamp_q;
				div_num   = (51'(vk) <<< 18) + (51'(vk) <<< 16);
				div_den   = {1'b0, mag_q};
			end
			WR_V: vw_we = 1'b1;
			EMIT: pw_we = slot_free;
			default: ;
		endcase
	end

	bfs_ram #(.WIDTH(96), .DEPTH(MAX_BOIDS)) u_pos_ram (
		.clk(clk), .we(pw_we), .waddr(pw_addr), .wdata(pw_data),
		.re(rd_re), .raddr(rd_addr), .rdata(pos_rdata)
	);

	bfs_ram #(.WIDTH(96), .DEPTH(MAX_BOIDS)) u_vel_ram (
		.clk(clk), .we(vw_we), .waddr(vw_addr), .wdata(vw_data),
		.re(rd_re), .raddr(rd_addr), .rdata(vel_rdata)
	);

	bfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.quo(div_q), .stat(div_st)
	);

	bfs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(m2_q), .root(sq_root),
		.stat(sq_st)
	);

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q  <= '0;
			vvld_q  <= '0;
			pvld_s1 <= 1'b0;
			vvld_s1 <= 1'b0;
		end else begin
			if (pw_we)
				pvld_q[pw_addr] <= 1'b1;
			if (vw_we)
				vvld_q[vw_addr] <= 1'b1;
			if (rd_re) begin
				pvld_s1 <= pvld_q[rd_addr];
				vvld_s1 <= vvld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= IDLE;
			bc_q      <= 6'd32;
			per_q     <= 16'd45;
			elapsed_q <= '0;
			ov_q      <= 1'b0;
			trig_q    <= 1'b0;
			clamp_q   <= 1'b0;
			n_q       <= 6'd2;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOID_COUNT:    bc_q  <= cfg_data[5:0];
					REG_UPDATE_PERIOD: per_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready)
				ov_q <= 1'b0;

			unique case (st_q)
				IDLE: begin
					if (in_fire) begin
						if (in_ch.command == CMD_LOAD) begin
							eidx_q  <= in_ch.boid_index;
							np_q[0] <= in_ch.pos_x;
							np_q[1] <= in_ch.pos_y;
							np_q[2] <= in_ch.pos_z;
							st_q    <= LD_EMIT;
						end else begin
							dt_q      <= in_ch.time_step;
							inten_q   <= in_ch.intensity;
							tend_q    <= 18'sd65536 - signed'({1'b0, in_ch.intensity});
							trig_q    <= enew > {16'b0, per_q};
							elapsed_q <= (enew > {16'b0, per_q}) ? 32'd0 : enew;
							n_q       <= n_new;
							i_q       <= '0;
							st_q      <= RD_I;
						end
					end
				end
				LD_EMIT: begin
					if (slot_free) begin
						ov_q    <= 1'b1;
						oidx_q  <= eidx_q;
						ox_q    <= np_q[0];
						oy_q    <= np_q[1];
						oz_q    <= np_q[2];
						olast_q <= 1'b1;
						st_q    <= IDLE;
					end
				end
				RD_I: st_q <= CAP_I;
				CAP_I: begin
					for (int a = 0; a < 3; a++) begin
						p_q[a]   <= signed'(pos_rd[32*a +: 32]);
						v_q[a]   <= signed'(vel_rd[32*a +: 32]);
						sp_q[a]  <= '0;
						sv_q[a]  <= '0;
						col_q[a] <= '0;
					end
					j_q  <= '0;
					k_q  <= '0;
					st_q <= trig_q ? J_RD : MV_SET;
				end
				J_RD: begin
					if (j_q == n_q) begin
						k_q  <= '0;
						m2_q <= '0;
						st_q <= M2_SET;
					end else if (j_q == i_q)
						j_q <= j_q + 6'd1;
					else
						st_q <= J_CAP;
				end
				J_CAP: begin
					for (int a = 0; a < 3; a++) begin
						sp_q[a] <= sp_q[a] + 37'(signed'(pos_rd[32*a +: 32]));
						sv_q[a] <= sv_q[a] + 37'(signed'(vel_rd[32*a +: 32]));
						d_q[a]  <= 33'(signed'(pos_rd[32*a +: 32])) - 33'(p_q[a]);
					end
					sq_q <= '0;
					k_q  <= '0;
					st_q <= J_SQ;
				end
				J_SQ: begin
					sq_q <= sq_q + unsigned'(sqv);
					if (k_q == 2'd2)
						st_q <= J_COL;
					else
						k_q <= k_q + 2'd1;
				end
				J_COL: begin
					if (near && sq_q < NEAR_D2)
						for (int a = 0; a < 3; a++)
							col_q[a] <= col_q[a] - d_q[a][20:0];
					j_q  <= j_q + 6'd1;
					st_q <= J_RD;
				end
				M2_SET: begin
					ma_q <= 34'(vk);
					mb_q <= 34'(vk);
					st_q <= M2_CAP;
				end
				M2_CAP: begin
					m2_q <= m2_q + prod[63:0];
					if (k_q == 2'd2)
						st_q <= M2_CHK;
					else begin
						k_q  <= k_q + 2'd1;
						st_q <= M2_SET;
					end
				end
				M2_CHK: begin
					clamp_q <= m2_q > CLAMP_M2;
					k_q     <= '0;
					st_q    <= (m2_q > CLAMP_M2) ? SQ_WAIT : K_DIVC;
				end
				SQ_WAIT: begin
					if (sq_st.done) begin
						mag_q <= sq_root;
						st_q  <= K_DIVC;
					end
				end
				K_DIVC: st_q <= K_WDIVC;
				K_WDIVC: begin
					if (div_st.done) begin
						ma_q <= 34'(signed'(div_q[31:0])) - 34'(pk);
						mb_q <= GAIN_COH;
						st_q <= K_CCAP;
					end
				end
				K_CCAP: begin
					acc_q <= (p16 + 40'(col_q[k_q])) + push_k;
					st_q  <= K_WDIVA;
				end
				K_WDIVA: begin
					if (div_st.done) begin
						acc_q <= acc_q + 40'(dv >>> 3);
						st_q  <= K_TEND;
					end
				end
				K_TEND: begin
					if (tend_q > TEND_THR) begin
						ma_q <= negp;
						mb_q <= 34'(tend_q);
						st_q <= K_TCAP;
					end else begin
						acc_q <= acc_q + 40'(negp >>> 20);
						st_q  <= K_DIVV;
					end
				end
				K_TCAP: begin
					acc_q <= acc_q + p16;
					st_q  <= K_DIVV;
				end
				K_DIVV, K_WDIVV: begin
					if (st_q == K_DIVV && clamp_q)
						st_q <= K_WDIVV;
					else if (st_q == K_DIVV || div_st.done) begin
						v_q[k_q] <= sat32(48'(vc) + 48'(acc_q));
						if (k_q == 2'd2)
							st_q <= WR_V;
						else begin
							k_q  <= k_q + 2'd1;
							st_q <= K_DIVC;
						end
					end
				end
				WR_V: begin
					k_q  <= '0;
					st_q <= MV_SET;
				end
				MV_SET: begin
					ma_q <= 34'(vk);
					mb_q <= signed'({18'b0, dt_q});
					st_q <= MV_CAP;
				end
				MV_CAP: begin
					np_q[k_q] <= sat32(48'(pk) + 48'(p16));
					if (k_q == 2'd2)
						st_q <= EMIT;
					else begin
						k_q  <= k_q + 2'd1;
						st_q <= MV_SET;
					end
				end
				EMIT: begin
					// hold until the output register is free
					if (slot_free) begin
						ov_q    <= 1'b1;
						oidx_q  <= i_q[4:0];
						ox_q    <= np_q[0];
						oy_q    <= np_q[1];
						oz_q    <= np_q[2];
						olast_q <= (i_q + 6'd1 == n_q);
						if (i_q + 6'd1 == n_q)
							st_q <= IDLE;
						else begin
							i_q  <= i_q + 6'd1;
							st_q <= RD_I;
						end
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign out_ch.valid     = ov_q;
	assign out_ch.out_index = oidx_q;
	assign out_ch.out_x     = ox_q;
	assign out_ch.out_y     = oy_q;
	assign out_ch.out_z     = oz_q;
	assign out_ch.last      = olast_q;

	`BFS_ASSERT_IMPL(a_div_free, div_start, !div_st.busy, "divider started while busy")
	`BFS_ASSERT_IMPL(a_sqrt_free, sq_start, !sq_st.busy, "square root started while busy")
	`BFS_ASSERT_IMPL(a_pos_rw, pw_we && rd_re, pw_addr != rd_addr, "position RAM read/write clash")
	`BFS_ASSERT_NEXT(a_emit_hold, st_q == EMIT && !slot_free, st_q == EMIT, "result dropped on stall")
endmodule

[sim/tb.sv]
// Self-checking bench for boids_flocking_step_top: loads, ticks and rule updates.
// Depends on bfs_pkg, bfs_if and the RTL of the block; holds its own flock predictor.
`timescale 1ns / 1ps
module tb;
	import bfs_pkg::*;

	localparam int NB = 32;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic               command;
		logic [4:0]         boid_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        time_step;
		logic [16:0]        intensity;
	} flock_cmd_t;

	typedef struct {
		logic [4:0]         idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} boid_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	bfs_in_if  in_ch();
	bfs_out_if out_ch();

	boids_flocking_step_top #(.MAX_BOIDS(NB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	flock_cmd_t cmd_q[$];
	boid_pos_t  pos_expect_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	// predictor state
	logic signed [31:0] pos_st[NB][3];
	logic signed [31:0] vel_st[NB][3];
	logic [31:0] elapsed_acc;
	logic [5:0]  count_reg;
	logic [15:0] period_reg;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic signed [31:0] sat_word(input longint x);
		if (x > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint wall_push(input longint p, input longint lo, input longint hi,
			input longint push);
		if (p < lo * 65536)
			return push;
		if (p > hi * 65536)
			return -push;
		return 0;
	endfunction

	function automatic int boids_active();
		int n;
		n = int'(count_reg);
		if (n < 2)
			n = 2;
		if (n > NB)
			n = NB;
		return n;
	endfunction

	task automatic flock_rule(input int i, input int n, input longint inten);
		longint p[3], v[3], sp[3], sv[3], col[3], acc[3], d[3];
		longint c, a, mag, push, tend;
		longint unsigned m2;
		bit near;
		push = 10 * inten;
		tend = 65536 - inten;
		m2 = 0;
		for (int k = 0; k < 3; k++) begin
			p[k] = longint'(pos_st[i][k]);
			v[k] = longint'(vel_st[i][k]);
			sp[k] = 0;
			sv[k] = 0;
			col[k] = 0;
		end
		for (int j = 0; j < n; j++) begin
			if (j != i) begin
				near = 1'b1;
				for (int k = 0; k < 3; k++) begin
					sp[k] += longint'(pos_st[j][k]);
					sv[k] += longint'(vel_st[j][k]);
					d[k] = longint'(pos_st[j][k]) - p[k];
					if (d[k] <= -32768 || d[k] >= 32768)
						near = 1'b0;
				end
				if (near && d[0] * d[0] + d[1] * d[1] + d[2] * d[2] < (64'sd1 << 30)) begin
					for (int k = 0; k < 3; k++)
						col[k] -= d[k];
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			c = sp[k] / longint'(n - 1);
			a = sv[k] / longint'(n - 1);
			acc[k] = (((c - p[k]) * 6553) >>> 16) + col[k] + ((a - v[k]) >>> 3);
			if (tend > 52428)
				acc[k] += (-p[k] * tend) >>> 16;
			else
				acc[k] += (-p[k]) >>> 20;
			m2 += longint'(v[k] * v[k]);
		end
		acc[0] += wall_push(p[0], -30, 30, push);
		acc[1] += wall_push(p[1], -50, 10, push);
		acc[2] += wall_push(p[2], -150, 10, push);
		// rescale the old velocity to magnitude 5
		if (m2 > (64'd25 << 32)) begin
			mag = longint'(int_sqrt(m2));
			for (int k = 0; k < 3; k++)
				v[k] = (v[k] * 327680) / mag;
		end
		for (int k = 0; k < 3; k++)
			vel_st[i][k] = sat_word(v[k] + acc[k]);
	endtask

	task automatic predict_flock(input flock_cmd_t c);
		boid_pos_t r;
		longint dt, inten;
		longint unsigned sum;
		bit trig;
		int n;
		if (c.command == CMD_LOAD) begin
			pos_st[c.boid_index][0] = c.pos_x;
			pos_st[c.boid_index][1] = c.pos_y;
			pos_st[c.boid_index][2] = c.pos_z;
			for (int k = 0; k < 3; k++)
				vel_st[c.boid_index][k] = '0;
			r.idx = c.boid_index;
			r.x = c.pos_x;
			r.y = c.pos_y;
			r.z = c.pos_z;
			r.last = 1'b1;
			pos_expect_q.push_back(r);
		end else begin
			dt = longint'(c.time_step);
			inten = longint'(c.intensity);
			sum = longint'(elapsed_acc) + dt;
			elapsed_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			trig = elapsed_acc > period_reg;
			n = boids_active();
			for (int i = 0; i < n; i++) begin
				if (trig)
					flock_rule(i, n, inten);
				for (int k = 0; k < 3; k++)
					pos_st[i][k] = sat_word(longint'(pos_st[i][k]) +
						((longint'(vel_st[i][k]) * dt) >>> 16));
				r.idx = 5'(i);
				r.x = pos_st[i][0];
				r.y = pos_st[i][1];
				r.z = pos_st[i][2];
				r.last = (i == n - 1);
				pos_expect_q.push_back(r);
			end
			if (trig)
				elapsed_acc = '0;
		end
	endtask

	// driver: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		flock_cmd_t c;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				c.command = in_ch.command;
				c.boid_index = in_ch.boid_index;
				c.pos_x = in_ch.pos_x;
				c.pos_y = in_ch.pos_y;
				c.pos_z = in_ch.pos_z;
				c.time_step = in_ch.time_step;
				c.intensity = in_ch.intensity;
				predict_flock(c);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					c = cmd_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= c.command;
					in_ch.boid_index <= c.boid_index;
					in_ch.pos_x <= c.pos_x;
					in_ch.pos_y <= c.pos_y;
					in_ch.pos_z <= c.pos_z;
					in_ch.time_step <= c.time_step;
					in_ch.intensity <= c.intensity;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		boid_pos_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pos_expect_q.size() == 0) begin
					report_mismatch("unexpected beat, index", out_ch.out_index, -1);
				end else begin
					e = pos_expect_q.pop_front();
					if (out_ch.out_index !== e.idx)
						report_mismatch("out_index", out_ch.out_index, e.idx);
					if (out_ch.out_x !== e.x)
						report_mismatch("out_x", out_ch.out_x, e.x);
					if (out_ch.out_y !== e.y)
						report_mismatch("out_y", out_ch.out_y, e.y);
					if (out_ch.out_z !== e.z)
						report_mismatch("out_z", out_ch.out_z, e.z);
					if (out_ch.last !== e.last)
						report_mismatch("last", out_ch.last, e.last);
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BOID_COUNT)
			count_reg = val[5:0];
		else
			period_reg = val;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (cmd_q.size() != 0 || in_ch.valid || pos_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_load(input int idx, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		flock_cmd_t c;
		c.command = CMD_LOAD;
		c.boid_index = 5'(idx);
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		c.time_step = 16'($urandom);
		c.intensity = 17'($urandom);
		cmd_q.push_back(c);
	endtask

	task automatic send_tick(input int dt, input int inten);
		flock_cmd_t c;
		c.command = CMD_TICK;
		c.boid_index = 5'($urandom);
		c.pos_x = $urandom;
		c.pos_y = $urandom;
		c.pos_z = $urandom;
		c.time_step = 16'(dt);
		c.intensity = 17'(inten);
		cmd_q.push_back(c);
	endtask

	function automatic logic [31:0] rand_coord(input logic [31:0] center);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
		if (sel < 8)
			return center + $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
		return $urandom;
	endfunction

	function automatic int rand_inten();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 65536;
		if (sel == 2)
			return $urandom_range(0, 13107);
		return $urandom_range(0, 65536);
	endfunction

	task automatic random_phase(input int items, input int nmax);
		logic [31:0] cx, cy, cz;
		cx = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		cy = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		cz = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 99) < 45) begin
				if ($urandom_range(0, 9) == 0)
					send_load($urandom_range(0, 31), rand_coord(cx), rand_coord(cy),
						rand_coord(cz));
				else
					send_load($urandom_range(0, nmax - 1), rand_coord(cx), rand_coord(cy),
						rand_coord(cz));
			end else begin
				send_tick($urandom_range(0, 65535), rand_inten());
			end
		end
		wait_drained();
		repeat (40) @(posedge clk);
	endtask

	task automatic set_mode(input int cnt, input int period, input int sidle, input int rstall);
		write_reg(REG_BOID_COUNT, {10'($urandom_range(0, 1023)), cnt[5:0]});
		write_reg(REG_UPDATE_PERIOD, period[15:0]);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD;
		in_ch.boid_index = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.time_step = '0;
		in_ch.intensity = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < NB; i++)
			for (int k = 0; k < 3; k++) begin
				pos_st[i][k] = '0;
				vel_st[i][k] = '0;
			end
		elapsed_acc = '0;
		count_reg = 6'd32;
		period_reg = 16'd45;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: count below two clamps to two, update on every tick
		set_mode(1, 0, 0, 0);
		send_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_load(1, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FD00);
		send_load(31, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_tick(65535, 0);
		send_tick(65535, 65536);
		wait_drained();
		// hold the sender until everything is back
		send_load(0, 32'h0000_0000, 32'h0000_4000, 32'h0000_0000);
		send_load(1, 32'h0000_2000, 32'h0000_0000, 32'h0000_1000);
		wait_drained();
		send_tick(0, 13107);
		send_tick(1, 13108);
		send_tick(65535, 65536);
		send_tick(65535, 65536);
		send_tick(65535, 1);
		send_load(1, 32'h0032_0000, 32'hFFB0_0000, 32'hFF00_0000);
		send_tick(40000, 32768);
		send_tick(65535, 65535);
		wait_drained();
		repeat (40) @(posedge clk);
		// period at its top, elapsed must pass it over several ticks
		set_mode(3, 65535, 0, 0);
		send_tick(65535, 20000);
		send_tick(0, 20000);
		send_tick(1, 20000);
		send_tick(1, 20000);
		wait_drained();
		repeat (40) @(posedge clk);

		set_mode(4, 0, 0, 0);
		random_phase(12, 4);
		set_mode($urandom_range(2, 8), $urandom_range(0, 65535), 48, 0);
		random_phase(12, 8);
		set_mode(6, 65535, 0, 48);
		random_phase(12, 6);
		set_mode(63, 30000, 21, 21);
		for (int i = 0; i < 32; i++)
			send_load(i, $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
				$urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
				$urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
		send_tick(20000, rand_inten());
		send_tick(20000, rand_inten());
		send_tick(65535, rand_inten());
		wait_drained();
		repeat (40) @(posedge clk);
		set_mode(0, 45, 0, 0);
		random_phase(10, 2);

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
